### design/bitmap_allocation_map_assert.svh
// Assertion macros for the allocation bitmap.
`ifndef BITMAP_ALLOCATION_MAP_ASSERT_SVH
`define BITMAP_ALLOCATION_MAP_ASSERT_SVH

`ifndef SYNTH
`define BAM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bitmap_allocation_map: same-cycle check failed");
`define BAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bitmap_allocation_map: next-cycle check failed");
`else
`define BAM_ASSERT_SAME(label, ante, cons)
`define BAM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/bam_pkg.sv
`default_nettype none

package bam_pkg;

    localparam int unsigned CAPACITY_DEFAULT = 1024;

    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_TEST  = 2'd2,
        FUNC_FIND  = 2'd3
    } func_t;

endpackage

`default_nettype wire

### design/bitmap_allocation_map.sv
`default_nettype none
`include "bitmap_allocation_map_assert.svh"
// Allocation bitmap with set, clear, test and find-first-set/clear.
// Input channel s_*: one operation per beat (func, position, wanted_value).
// Result channel m_*: exactly one result beat per input beat, in order.
// cfg_wr_en/cfg_wr_data write entries_in_use (effective size is the smaller
// of it and CAPACITY); write it only while no beat is in flight.
// The map lives in a RAM of 32-bit words (8-bit words below 32 entries) with
// a registered read port; one shared word compare/priority-encode unit scans it.
// Set, clear and test read the addressed word into the read register, then
// load the output register (set/clear write the word back with it).
// Find reads one word per cycle starting at the word holding position and
// stops at a match, at the word of the last in-use entry or at once if out
// of range; the next input beat is taken only once the result is loaded.
// After reset a clearing pass writes every RAM word to zero, one word per
// cycle; s_ready stays low during it.
// A new input beat is taken while a result still waits in the output
// register; when m_ready is low the next result holds inside until the
// output register frees up.
module bitmap_allocation_map #(
    parameter int unsigned CAPACITY = bam_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [$clog2(CAPACITY):0]     cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire bam_pkg::func_t                s_func,
    input  wire logic [$clog2(CAPACITY)-1:0]   s_position,
    input  wire logic                          s_wanted_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_bit_value,
    output logic                               m_found,
    output logic [$clog2(CAPACITY)-1:0]        m_found_position
);
    import bam_pkg::*;

    localparam int unsigned POS_W  = $clog2(CAPACITY);
    localparam int unsigned CFG_W  = POS_W + 1;
    localparam int unsigned WORD_W = (CAPACITY >= 32) ? 32 : 8;
    localparam int unsigned BIT_W  = $clog2(WORD_W);
    localparam int unsigned WORDS  = (CAPACITY + WORD_W - 1) / WORD_W;
    localparam int unsigned IDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [CFG_W-1:0] CAP_VAL = CFG_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                 state_reg;
    logic [IDX_W-1:0]       clr_reg;
    logic [CFG_W-1:0]       entries_reg;

    func_t                  func_reg;
    logic                   want_reg;
    logic                   in_range_reg;
    logic                   first_reg;
    logic [BIT_W-1:0]       start_bit_reg;
    logic [IDX_W-1:0]       cur_reg;
    logic [IDX_W-1:0]       last_word_reg;
    logic [BIT_W-1:0]       last_bit_reg;

    logic [WORD_W-1:0]      mem [WORDS];
    logic [WORD_W-1:0]      rdata_reg;

    logic                   m_valid_reg;
    logic                   m_bit_value_reg;
    logic                   m_found_reg;
    logic [POS_W-1:0]       m_found_position_reg;

    logic [CFG_W-1:0]       size;
    logic [CFG_W-1:0]       size_m1;
    logic                   accept;
    logic                   out_free;
    logic [IDX_W-1:0]       pos_word;
    logic [IDX_W-1:0]       rd_addr;
    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [WORD_W-1:0]      wdata;
    logic [WORD_W-1:0]      cand;
    logic                   hit;
    logic [BIT_W-1:0]       hit_bit;
    logic                   done;
    logic                   is_find;
    logic                   result_load;

    assign size     = (entries_reg > CAP_VAL) ? CAP_VAL : entries_reg;
    assign size_m1  = size - CFG_W'(1);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign pos_word = IDX_W'(s_position >> BIT_W);
    assign is_find  = (func_reg == FUNC_FIND);

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            cand[b] = (rdata_reg[b] == want_reg)
                   && (!first_reg || (BIT_W'(b) >= start_bit_reg))
                   && ((cur_reg != last_word_reg) || (BIT_W'(b) <= last_bit_reg));
        end
    end

    always_comb begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                hit     = 1'b1;
                hit_bit = BIT_W'(b);
            end
        end
    end

    assign done = !is_find || !in_range_reg || hit || (cur_reg == last_word_reg);
    assign result_load = (state_reg == ST_EXEC) && done && out_free;

    always_comb begin
        priority if (state_reg == ST_IDLE) begin
            rd_addr = pos_word;
        end else if (state_reg == ST_EXEC && !done) begin
            rd_addr = cur_reg + IDX_W'(1);
        end else begin
            rd_addr = cur_reg;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = cur_reg;
        wdata = rdata_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
            end
            ST_EXEC: begin
                we = done && out_free && in_range_reg
                     && (func_reg == FUNC_SET || func_reg == FUNC_CLEAR);
                wdata[start_bit_reg] = (func_reg == FUNC_SET);
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            entries_reg <= CAP_VAL;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                entries_reg <= cfg_wr_data;
            end
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == LAST_IDX) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        state_reg     <= ST_EXEC;
                        func_reg      <= s_func;
                        want_reg      <= s_wanted_value;
                        in_range_reg  <= (CFG_W'(s_position) < size);
                        first_reg     <= 1'b1;
                        start_bit_reg <= s_position[BIT_W-1:0];
                        cur_reg       <= pos_word;
                        last_word_reg <= IDX_W'(size_m1 >> BIT_W);
                        last_bit_reg  <= size_m1[BIT_W-1:0];
                    end
                end
                ST_EXEC: begin
                    if (!done) begin
                        cur_reg   <= cur_reg + IDX_W'(1);
                        first_reg <= 1'b0;
                    end else if (out_free) begin
                        state_reg       <= ST_IDLE;
                        m_bit_value_reg <= (func_reg == FUNC_TEST) && in_range_reg
                                           && rdata_reg[start_bit_reg];
                        m_found_reg     <= is_find && in_range_reg && hit;
                        m_found_position_reg <= (is_find && in_range_reg && hit)
                                                ? POS_W'({cur_reg, hit_bit}) : '0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_bit_value      = m_bit_value_reg;
    assign m_found          = m_found_reg;
    assign m_found_position = m_found_position_reg;

    `BAM_ASSERT_NEXT(a_busy_after_accept, accept, !s_ready)
    `BAM_ASSERT_SAME(a_test_find_exclusive, m_valid && m_bit_value, !m_found)
    `BAM_ASSERT_SAME(a_miss_zero_position, m_valid && !m_found, m_found_position == '0)
    `BAM_ASSERT_SAME(a_hit_in_use, m_valid && m_found, CFG_W'(m_found_position) < size)

endmodule

`default_nettype wire

### tb/bitmap_allocation_map_checker.sv
`timescale 1ns / 100ps

module bitmap_allocation_map_checker #(
    parameter int unsigned CAPACITY = bam_pkg::CAPACITY_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [$clog2(CAPACITY):0]     cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  bam_pkg::func_t                s_func,
    input  logic [$clog2(CAPACITY)-1:0]   s_position,
    input  logic                          s_wanted_value,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_bit_value,
    input  logic                          m_found,
    input  logic [$clog2(CAPACITY)-1:0]   m_found_position,
    output int unsigned                   fail_count,
    output int unsigned                   results_due,
    output int unsigned                   finds_hit,
    output int unsigned                   finds_missed
);

    import bam_pkg::*;

    localparam int unsigned POS_W = $clog2(CAPACITY);
    localparam int unsigned RESET_SIZE = 1024;

    typedef struct packed {
        logic             bit_value;
        logic             found;
        logic [POS_W-1:0] found_position;
    } map_reply_t;

    logic [CAPACITY-1:0] alloc_bits;
    logic [POS_W:0]      size_reg;
    map_reply_t          replies_due [$];
    int unsigned         errors_seen;
    int unsigned         hits;
    int unsigned         misses;

    function automatic map_reply_t predict_reply(func_t op, logic [POS_W-1:0] pos,
                                                 logic want);
        map_reply_t  reply;
        int unsigned span;
        span = (size_reg > CAPACITY) ? CAPACITY : size_reg;
        reply = '0;
        case (op)
            FUNC_SET: begin
                if (pos < span) alloc_bits[pos] = 1'b1;
            end
            FUNC_CLEAR: begin
                if (pos < span) alloc_bits[pos] = 1'b0;
            end
            FUNC_TEST: begin
                if (pos < span) reply.bit_value = alloc_bits[pos];
            end
            default: begin
                for (int unsigned i = pos; i < span && !reply.found; i++) begin
                    if (alloc_bits[i] == want) begin
                        reply.found = 1'b1;
                        reply.found_position = i[POS_W-1:0];
                    end
                end
            end
        endcase
        return reply;
    endfunction

    function automatic int unsigned field_differs(string field, logic [POS_W-1:0] expected,
                                                  logic [POS_W-1:0] actual);
        if (expected !== actual) begin
            $error("%s: expected %0d, got %0d", field, expected, actual);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        map_reply_t due;
        map_reply_t reply;
        if (!aresetn) begin
            alloc_bits = '0;
            size_reg = (POS_W + 1)'(RESET_SIZE);
            replies_due.delete();
            errors_seen = 0;
            hits = 0;
            misses = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("result beat with no operation pending");
                    errors_seen++;
                end else begin
                    due = replies_due.pop_front();
                    errors_seen += field_differs("bit_value", due.bit_value, m_bit_value)
                        + field_differs("found", due.found, m_found)
                        + field_differs("found_position", due.found_position,
                                        m_found_position);
                end
            end
            if (s_valid && s_ready) begin
                reply = predict_reply(s_func, s_position, s_wanted_value);
                if (s_func == FUNC_FIND) begin
                    if (reply.found) hits++;
                    else misses++;
                end
                replies_due.push_back(reply);
            end
            if (cfg_wr_en) size_reg = cfg_wr_data;
        end
        fail_count   <= errors_seen;
        results_due  <= replies_due.size();
        finds_hit    <= hits;
        finds_missed <= misses;
    end

endmodule

### tb/bitmap_allocation_map_test.sv
`timescale 1ns / 100ps

module bitmap_allocation_map_test;

    import bam_pkg::*;

    localparam int unsigned CAPACITY = CAPACITY_DEFAULT;
    localparam int unsigned POS_W = $clog2(CAPACITY);
    localparam int unsigned CLK_PERIOD = 12;
    localparam int unsigned RESET_CYCLES = 8;
    localparam int unsigned MAX_PAUSE = 14;
    localparam int unsigned PHASES = 13;
    localparam int unsigned OPS_PER_PHASE = 105;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [POS_W:0]   cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    func_t            s_func;
    logic [POS_W-1:0] s_position;
    logic             s_wanted_value;
    logic             m_valid;
    logic             m_ready;
    logic             m_bit_value;
    logic             m_found;
    logic [POS_W-1:0] m_found_position;

    int unsigned fail_count;
    int unsigned results_due;
    int unsigned finds_hit;
    int unsigned finds_missed;
    int unsigned ops_sent = 0;
    int unsigned sizes_tried = 1;
    int unsigned map_size = 1024;
    bit          pace_sender = 1'b1;
    bit          pace_receiver = 1'b1;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    bitmap_allocation_map #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_position(s_position),
        .s_wanted_value(s_wanted_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_bit_value(m_bit_value),
        .m_found(m_found),
        .m_found_position(m_found_position)
    );

    bitmap_allocation_map_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_position(s_position),
        .s_wanted_value(s_wanted_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_bit_value(m_bit_value),
        .m_found(m_found),
        .m_found_position(m_found_position),
        .fail_count(fail_count),
        .results_due(results_due),
        .finds_hit(finds_hit),
        .finds_missed(finds_missed)
    );

    task automatic send_op(func_t op, logic [POS_W-1:0] pos, logic want);
        int unsigned pause;
        pause = pace_sender ? $urandom_range(0, MAX_PAUSE) : 0;
        if (pause != 0) begin
            s_valid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= op;
        s_position     <= pos;
        s_wanted_value <= want;
        do @(posedge aclk); while (!s_ready);
        ops_sent++;
    endtask

    task automatic send_random_op(int unsigned set_share);
        int unsigned span;
        int unsigned pos;
        int unsigned pick;
        logic        want;
        func_t       op;
        span = (map_size > CAPACITY) ? CAPACITY : map_size;
        if (span == 0 || $urandom_range(0, 3) == 0) pos = $urandom_range(0, CAPACITY - 1);
        else pos = $urandom_range(0, span);
        if (pos > CAPACITY - 1) pos = CAPACITY - 1;
        pick = $urandom_range(0, 99);
        if (pick < 30) op = FUNC_FIND;
        else if (pick < 45) op = FUNC_TEST;
        else if ($urandom_range(0, 99) < set_share) op = FUNC_SET;
        else op = FUNC_CLEAR;
        want = 1'($urandom_range(0, 1));
        send_op(op, pos[POS_W-1:0], want);
    endtask

    task automatic resize_map(int unsigned size);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size[POS_W:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        map_size = size;
        sizes_tried++;
    endtask

    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = pace_receiver ? $urandom_range(0, MAX_PAUSE) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet = 0;
            else quiet++;
        end
        $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** bitmap_allocation_map: FAILED **");
        $finish;
    end

    initial begin
        int unsigned next_size;
        int unsigned set_share;
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        s_valid        <= 1'b0;
        s_func         <= FUNC_SET;
        s_position     <= '0;
        s_wanted_value <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        send_op(FUNC_FIND, POS_W'(0), 1'b1);
        send_op(FUNC_FIND, POS_W'(1023), 1'b0);
        send_op(FUNC_SET, POS_W'(0), 1'b0);
        send_op(FUNC_SET, POS_W'(1023), 1'b1);
        send_op(FUNC_SET, POS_W'(31), 1'b0);
        send_op(FUNC_SET, POS_W'(32), 1'b1);
        send_op(FUNC_TEST, POS_W'(0), 1'b0);
        send_op(FUNC_TEST, POS_W'(1023), 1'b1);
        send_op(FUNC_TEST, POS_W'(1), 1'b0);
        send_op(FUNC_FIND, POS_W'(1), 1'b1);
        send_op(FUNC_FIND, POS_W'(33), 1'b1);
        send_op(FUNC_FIND, POS_W'(31), 1'b0);
        send_op(FUNC_CLEAR, POS_W'(1023), 1'b0);
        send_op(FUNC_FIND, POS_W'(33), 1'b1);
        resize_map(0);
        send_op(FUNC_CLEAR, POS_W'(0), 1'b0);
        send_op(FUNC_TEST, POS_W'(0), 1'b0);
        send_op(FUNC_FIND, POS_W'(0), 1'b0);
        resize_map(2047);
        send_op(FUNC_TEST, POS_W'(0), 1'b1);
        send_op(FUNC_FIND, POS_W'(1023), 1'b0);
        resize_map(1);
        send_op(FUNC_FIND, POS_W'(0), 1'b1);
        send_op(FUNC_SET, POS_W'(1), 1'b1);
        send_op(FUNC_TEST, POS_W'(1), 1'b0);
        send_op(FUNC_FIND, POS_W'(0), 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: next_size = 8;
                1: next_size = 2047;
                2: next_size = 32;
                3: next_size = 1023;
                4: next_size = 33;
                5: next_size = 0;
                6: next_size = 1024;
                7: next_size = 5;
                8: next_size = 64;
                9: next_size = 1025;
                10: next_size = 1;
                default: next_size = $urandom_range(1, 2047);
            endcase
            resize_map(next_size);
            pace_sender = (phase % 4 == 0) || (phase % 4 == 2);
            pace_receiver = (phase % 4 == 0) || (phase % 4 == 3);
            set_share = $urandom_range(20, 80);
            repeat (OPS_PER_PHASE) send_random_op(set_share);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d operations over %0d map sizes, with and without idle gaps",
                 ops_sent, sizes_tried);
        $display("Searches: %0d found a match, %0d found none", finds_hit, finds_missed);
        if (fail_count == 0 && results_due == 0) begin
            $display("** bitmap_allocation_map: PASSED **");
        end else begin
            $display("** bitmap_allocation_map: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/bam_pkg.sv
design/bitmap_allocation_map.sv
tb/bitmap_allocation_map_checker.sv
tb/bitmap_allocation_map_test.sv
